// ----- rtl/atan2pa_pkg.sv -----
// ----------------------------------------------------------------------------
// atan2pa_pkg
// Shared constants and types for the pipelined atan2 polynomial core.
// ----------------------------------------------------------------------------
package atan2pa_pkg;

	localparam int INPUT_WIDTH_DEF = 16;

	// ratio magnitude in Q1.15, 0..32768
	localparam int FRAC_Z = 15;
	localparam int A_W    = FRAC_Z + 1;

	// restoring divider: two quotient bits per stage
	localparam int DIV_STAGES = A_W / 2;

	localparam int ANGLE_W = 16;
	localparam int P13_W   = 13;
	localparam int INNER_W = 15;
	localparam int A2_W    = 16;
	localparam int T_W     = 29;
	localparam int PROD_W  = 31;

	localparam logic [INNER_W-1:0]        COEF_N1     = 15'd31863;
	localparam logic [12:0]               COEF_N2_MAG = 13'd6290;
	localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;
	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;

	// per-item control that rides along with the arithmetic
	typedef struct packed {
		logic signed [ANGLE_W-1:0] base;
		logic                      use_cubic;
		logic                      neg;
	} side_t;

endpackage

// ----- rtl/atan2_polynomial_approx_core.sv -----
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_core
// Fixed-point atan2(y, x) with the ratio through a cubic, angle in Q3.13.
// ----------------------------------------------------------------------------
// pipeline stages from input transfer to result valid:
//   (1 select stage, 8 divider stages, 4 polynomial stages, 1 output stage)
// throughput: one transfer per cycle; the whole pipe holds while a result waits
// reset clears every valid bit; data registers are not reset
module atan2_polynomial_approx_core import atan2pa_pkg::*; #(
	parameter int INPUT_WIDTH = INPUT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [INPUT_WIDTH-1:0] y_value,
	input  logic signed [INPUT_WIDTH-1:0] x_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [ANGLE_W-1:0]     angle
);

	localparam int W = INPUT_WIDTH;

	logic en;

	logic [W-1:0] ymag, xmag;
	logic         swap;
	side_t        side_c;

	logic         valid_s1;
	logic [W-1:0] num_s1, den_s1;
	side_t        side_s1;

	logic           div_valid;
	logic [A_W-1:0] div_quo;
	side_t          div_side;

	logic             poly_valid;
	logic [P13_W-1:0] poly_p13;
	side_t            poly_side;

	logic signed [ANGLE_W-1:0] cubic_term;
	logic                      valid_q;
	logic signed [ANGLE_W-1:0] angle_q;

	assign en       = !valid_q || out_ready;
	assign in_ready = en;

	// operand selection and angle offsets
	always_comb begin
		ymag = y_value[W-1] ? W'(-y_value) : W'(y_value);
		xmag = x_value[W-1] ? W'(-x_value) : W'(x_value);
		swap = xmag < ymag;
		side_c = '0;
		if (x_value == '0) begin
			side_c.use_cubic = 1'b0;
			side_c.neg       = 1'b0;
			if (y_value[W-1]) begin
				side_c.base = -HALF_PI_Q13;
			end else if (y_value != '0) begin
				side_c.base = HALF_PI_Q13;
			end else begin
				side_c.base = '0;
			end
		end else if (!swap) begin
			side_c.use_cubic = 1'b1;
			side_c.neg       = y_value[W-1] ^ x_value[W-1];
			if (x_value[W-1]) begin
				side_c.base = y_value[W-1] ? -PI_Q13 : PI_Q13;
			end else begin
				side_c.base = '0;
			end
		end else begin
			// pi/2 with the sign of y, minus the cubic of x/y
			side_c.use_cubic = 1'b1;
			side_c.neg       = !(y_value[W-1] ^ x_value[W-1]);
			side_c.base      = y_value[W-1] ? -HALF_PI_Q13 : HALF_PI_Q13;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= swap ? xmag : ymag;
			den_s1  <= swap ? ymag : xmag;
			side_s1 <= side_c;
		end
	end

	atan2pa_div #(
		.W(W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s1),
		.num      (num_s1),
		.den      (den_s1),
		.in_side  (side_s1),
		.out_valid(div_valid),
		.quo      (div_quo),
		.out_side (div_side)
	);

	atan2pa_poly u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (div_valid),
		.a        (div_quo),
		.in_side  (div_side),
		.out_valid(poly_valid),
		.p13      (poly_p13),
		.out_side (poly_side)
	);

	always_comb begin
		if (!poly_side.use_cubic) begin
			cubic_term = '0;
		end else if (poly_side.neg) begin
			cubic_term = -$signed({{(ANGLE_W-P13_W){1'b0}}, poly_p13});
		end else begin
			cubic_term = $signed({{(ANGLE_W-P13_W){1'b0}}, poly_p13});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= poly_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= poly_side.base + cubic_term;
		end
	end

	assign out_valid = valid_q;
	assign angle     = angle_q;

endmodule

// ----- rtl/atan2pa_div.sv -----
// ----------------------------------------------------------------------------
// atan2pa_div
// Pipelined restoring divider: a = floor(num * 2^15 / den) for num <= den.
// ----------------------------------------------------------------------------
module atan2pa_div import atan2pa_pkg::*; #(
	parameter int W = INPUT_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [W-1:0]   num,
	input  logic [W-1:0]   den,
	input  side_t          in_side,
	output logic           out_valid,
	output logic [A_W-1:0] quo,
	output side_t          out_side
);

	logic           valid_s [DIV_STAGES];
	logic [W-1:0]   rem_s   [DIV_STAGES];
	logic [W-1:0]   den_s   [DIV_STAGES];
	logic [A_W-1:0] q_s     [DIV_STAGES];
	side_t          side_s  [DIV_STAGES];

	// one shift-compare-subtract step; msb of the result is the quotient bit
	function automatic logic [W:0] shift_step(input logic [W-1:0] rem,
			input logic [W-1:0] d);
		logic [W:0] r2;
		logic [W:0] diff;
		r2   = {rem, 1'b0};
		diff = r2 - {1'b0, d};
		if (r2 >= {1'b0, d}) begin
			return {1'b1, diff[W-1:0]};
		end else begin
			return {1'b0, r2[W-1:0]};
		end
	endfunction

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [W:0]     st_a;
		logic [W:0]     st_b;
		logic [W-1:0]   rem_in;
		logic [W-1:0]   den_in;
		logic [A_W-1:0] q_in;
		logic           valid_in;
		side_t          side_in;

		if (k == 0) begin : g_first
			logic [W-1:0] diff0;

			// leading bit: num may equal den, so no shift here
			always_comb begin
				diff0    = num - den;
				st_a     = (num >= den) ? {1'b1, diff0} : {1'b0, num};
				st_b     = shift_step(st_a[W-1:0], den);
				rem_in   = st_b[W-1:0];
				q_in     = A_W'({st_a[W], st_b[W]});
				den_in   = den;
				valid_in = in_valid;
				side_in  = in_side;
			end
		end else begin : g_rest
			always_comb begin
				st_a     = shift_step(rem_s[k-1], den_s[k-1]);
				st_b     = shift_step(st_a[W-1:0], den_s[k-1]);
				rem_in   = st_b[W-1:0];
				q_in     = {q_s[k-1][A_W-3:0], st_a[W], st_b[W]};
				den_in   = den_s[k-1];
				valid_in = valid_s[k-1];
				side_in  = side_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_in;
				den_s[k]  <= den_in;
				q_s[k]    <= q_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign quo       = q_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule

// ----- rtl/atan2pa_poly.sv -----
// ----------------------------------------------------------------------------
// atan2pa_poly
// Four-stage evaluation of the odd cubic n1*a + n2*a^3, rounded to Q0.13.
// ----------------------------------------------------------------------------
module atan2pa_poly import atan2pa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [A_W-1:0]   a,
	input  side_t            in_side,
	output logic             out_valid,
	output logic [P13_W-1:0] p13,
	output side_t            out_side
);

	localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_Z - 1);

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	side_t              side_s1, side_s2, side_s3, side_s4;
	logic [A_W-1:0]     a_s1, a_s2;
	logic [2*A_W-1:0]   sq_s1;
	logic [T_W-1:0]     t_s2;
	logic [PROD_W-1:0]  prod_s3;
	logic [P13_W-1:0]   p13_s4;

	logic [2*A_W-1:0]   sq_rnd;
	logic [A2_W-1:0]    a2;
	logic [T_W-1:0]     t_rnd;
	logic [INNER_W-1:0] inner;
	logic [PROD_W-1:0]  prod_rnd;
	logic [A_W:0]       p15_rnd;

	always_comb begin
		sq_rnd   = sq_s1 + (2*A_W)'(HALF);
		a2       = sq_rnd[FRAC_Z +: A2_W];
		t_rnd    = t_s2 + T_W'(HALF);
		inner    = COEF_N1 - INNER_W'(t_rnd[T_W-1:FRAC_Z]);
		prod_rnd = prod_s3 + HALF;
		p15_rnd  = {1'b0, prod_rnd[FRAC_Z +: A_W]} + (A_W+1)'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a;
			sq_s1   <= a * a;
			side_s1 <= in_side;

			a_s2    <= a_s1;
			t_s2    <= T_W'(a2) * T_W'(COEF_N2_MAG);
			side_s2 <= side_s1;

			prod_s3 <= PROD_W'(inner) * PROD_W'(a_s2);
			side_s3 <= side_s2;

			p13_s4  <= p15_rnd[2 +: P13_W];
			side_s4 <= side_s3;
		end
	end

	assign out_valid = valid_s4;
	assign p13       = p13_s4;
	assign out_side  = side_s4;

endmodule
